@@ rtl/core/kitt_pkg.sv @@
package kitt_pkg;

  typedef enum logic [1:0] {
    ACT_ADD          = 2'd0,
    ACT_REMOVE       = 2'd1,
    ACT_REMOVE_OWNER = 2'd2,
    ACT_TICK         = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_FULL  = 2'd2
  } kind_e;

  // One table entry as it is held in the slot memory.
  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] timer;
    logic [30:0] period;
    logic        one_shot;
    logic [31:0] elapsed;
  } slot_t;

  localparam int unsigned SlotWidth = $bits(slot_t);

endpackage

@@ rtl/core/kitt_req_if.sv @@
interface kitt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  owner_key;
  logic [15:0] timer_key;
  logic [30:0] period;
  logic        one_shot;
  logic [31:0] delta_time;

  modport source (
    output valid, action, owner_key, timer_key, period, one_shot, delta_time,
    input  ready
  );

  modport sink (
    input  valid, action, owner_key, timer_key, period, one_shot, delta_time,
    output ready
  );
endinterface

@@ rtl/core/kitt_rsp_if.sv @@
interface kitt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  fired_owner;
  logic [15:0] fired_timer;
  logic [31:0] fired_elapsed;
  logic        last;

  modport source (
    output valid, kind, fired_owner, fired_timer, fired_elapsed, last,
    input  ready
  );

  modport sink (
    input  valid, kind, fired_owner, fired_timer, fired_elapsed, last,
    output ready
  );
endinterface

@@ rtl/core/kitt_ram.sv @@
module kitt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/keyed_interval_timer_table.sv @@
// Table of SLOTS timers keyed by owner and timer number. Every transaction on
// req_i is swept over the whole table one slot at a time by a single shared
// adder and comparator, reading each live slot from a table memory with one
// write port and one registered read port. A live slot is read in S_READ and
// evaluated in S_EVAL; a free slot is passed in S_READ alone, with no read. A
// sweep stalls while rsp_o holds back a result. Req_i is ready only between
// sweeps. A tick returns one fired result per expiring timer in slot order,
// then a closing result with last set; every other transaction returns one
// result. The table needs no clearing pass after reset.
module keyed_interval_timer_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kitt_req_if.sink   req_i,
  kitt_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_WRITE,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  kitt_pkg::action_e   action_q, action_d;
  logic [7:0]          owner_q, owner_d;
  logic [15:0]         timer_q, timer_d;
  logic [30:0]         period_q, period_d;
  logic                shot_q, shot_d;
  logic [31:0]         delta_q, delta_d;
  logic                match_q, match_d;
  logic [IdxW-1:0]     match_idx_q, match_idx_d;
  logic                free_q, free_d;
  logic [IdxW-1:0]     free_idx_q, free_idx_d;
  kitt_pkg::kind_e     done_kind_q, done_kind_d;
  logic [SLOTS-1:0]    valid_q, valid_d;

  logic                out_valid_q, out_valid_d;
  kitt_pkg::kind_e     out_kind_q, out_kind_d;
  logic [7:0]          out_owner_q, out_owner_d;
  logic [15:0]         out_timer_q, out_timer_d;
  logic [31:0]         out_elapsed_q, out_elapsed_d;
  logic                out_last_q, out_last_d;

  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  kitt_pkg::slot_t     ram_wdata;
  logic                ram_re;
  logic [kitt_pkg::SlotWidth-1:0] ram_rdata;
  kitt_pkg::slot_t     slot;

  logic [32:0]         sum;
  logic [31:0]         elapsed_new;
  logic                fire;
  logic                can_load;
  logic                advance;

  kitt_ram #(
    .Width (kitt_pkg::SlotWidth),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign slot        = kitt_pkg::slot_t'(ram_rdata);
  assign sum         = {1'b0, slot.elapsed} + {1'b0, delta_q};
  assign elapsed_new = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign fire        = elapsed_new >= {1'b0, slot.period};
  assign can_load    = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    action_d      = action_q;
    owner_d       = owner_q;
    timer_d       = timer_q;
    period_d      = period_q;
    shot_d        = shot_q;
    delta_d       = delta_q;
    match_d       = match_q;
    match_idx_d   = match_idx_q;
    free_d        = free_q;
    free_idx_d    = free_idx_q;
    done_kind_d   = done_kind_q;
    valid_d       = valid_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    out_kind_d    = out_kind_q;
    out_owner_d   = out_owner_q;
    out_timer_d   = out_timer_q;
    out_elapsed_d = out_elapsed_q;
    out_last_d    = out_last_q;
    ram_we        = 1'b0;
    ram_waddr     = idx_q;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    advance       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          action_d    = kitt_pkg::action_e'(req_i.action);
          owner_d     = req_i.owner_key;
          timer_d     = req_i.timer_key;
          period_d    = req_i.period;
          shot_d      = req_i.one_shot;
          delta_d     = req_i.delta_time;
          idx_d       = '0;
          match_d     = 1'b0;
          free_d      = 1'b0;
          done_kind_d = kitt_pkg::KIND_DONE;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        if (valid_q[idx_q]) begin
          ram_re  = 1'b1;
          state_d = S_EVAL;
        end else begin
          if (action_q == kitt_pkg::ACT_ADD && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = idx_q;
          end
          advance = 1'b1;
        end
      end
      S_EVAL: begin
        unique case (action_q)
          kitt_pkg::ACT_ADD: begin
            if (slot.owner == owner_q && slot.timer == timer_q && !match_q) begin
              match_d     = 1'b1;
              match_idx_d = idx_q;
            end
            advance = 1'b1;
          end
          kitt_pkg::ACT_REMOVE: begin
            if (slot.owner == owner_q && slot.timer == timer_q) begin
              valid_d[idx_q] = 1'b0;
            end
            advance = 1'b1;
          end
          kitt_pkg::ACT_REMOVE_OWNER: begin
            if (slot.owner == owner_q) begin
              valid_d[idx_q] = 1'b0;
            end
            advance = 1'b1;
          end
          kitt_pkg::ACT_TICK: begin
            if (!fire) begin
              ram_we            = 1'b1;
              ram_wdata         = slot;
              ram_wdata.elapsed = elapsed_new;
              advance           = 1'b1;
            end else if (can_load) begin
              out_valid_d   = 1'b1;
              out_kind_d    = kitt_pkg::KIND_FIRED;
              out_owner_d   = slot.owner;
              out_timer_d   = slot.timer;
              out_elapsed_d = elapsed_new;
              out_last_d    = 1'b0;
              if (slot.one_shot) begin
                valid_d[idx_q] = 1'b0;
              end else begin
                ram_we            = 1'b1;
                ram_wdata         = slot;
                ram_wdata.elapsed = '0;
              end
              advance = 1'b1;
            end
          end
          default: begin
            advance = 1'b1;
          end
        endcase
      end
      S_WRITE: begin
        ram_wdata.owner    = owner_q;
        ram_wdata.timer    = timer_q;
        ram_wdata.period   = period_q;
        ram_wdata.one_shot = shot_q;
        ram_wdata.elapsed  = '0;
        if (match_q || free_q) begin
          ram_we             = 1'b1;
          ram_waddr          = match_q ? match_idx_q : free_idx_q;
          valid_d[ram_waddr] = 1'b1;
        end else begin
          done_kind_d = kitt_pkg::KIND_FULL;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (can_load) begin
          out_valid_d   = 1'b1;
          out_kind_d    = done_kind_q;
          out_owner_d   = '0;
          out_timer_d   = '0;
          out_elapsed_d = '0;
          out_last_d    = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (advance) begin
      if (idx_q == LastIdx) begin
        state_d = (action_q == kitt_pkg::ACT_ADD) ? S_WRITE : S_DONE;
      end else begin
        idx_d   = idx_q + 1'b1;
        state_d = S_READ;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      action_q      <= kitt_pkg::ACT_ADD;
      owner_q       <= '0;
      timer_q       <= '0;
      period_q      <= '0;
      shot_q        <= 1'b0;
      delta_q       <= '0;
      match_q       <= 1'b0;
      match_idx_q   <= '0;
      free_q        <= 1'b0;
      free_idx_q    <= '0;
      done_kind_q   <= kitt_pkg::KIND_DONE;
      valid_q       <= '0;
      out_valid_q   <= 1'b0;
      out_kind_q    <= kitt_pkg::KIND_DONE;
      out_owner_q   <= '0;
      out_timer_q   <= '0;
      out_elapsed_q <= '0;
      out_last_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      action_q      <= action_d;
      owner_q       <= owner_d;
      timer_q       <= timer_d;
      period_q      <= period_d;
      shot_q        <= shot_d;
      delta_q       <= delta_d;
      match_q       <= match_d;
      match_idx_q   <= match_idx_d;
      free_q        <= free_d;
      free_idx_q    <= free_idx_d;
      done_kind_q   <= done_kind_d;
      valid_q       <= valid_d;
      out_valid_q   <= out_valid_d;
      out_kind_q    <= out_kind_d;
      out_owner_q   <= out_owner_d;
      out_timer_q   <= out_timer_d;
      out_elapsed_q <= out_elapsed_d;
      out_last_q    <= out_last_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.kind          = out_kind_q;
  assign rsp_o.fired_owner   = out_owner_q;
  assign rsp_o.fired_timer   = out_timer_q;
  assign rsp_o.fired_elapsed = out_elapsed_q;
  assign rsp_o.last          = out_last_q;

endmodule

@@ tb/sv/tb_keyed_interval_timer_table.sv @@
`timescale 1ns / 1ps

module tb_keyed_interval_timer_table;
  import kitt_pkg::*;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned SweepCycles = 2 * NumSlots + 8;

  typedef struct {
    kind_e       kind;
    logic [7:0]  owner;
    logic [15:0] timer;
    logic [31:0] elapsed;
    logic        last;
  } timer_result_t;

  logic clk;
  logic rst_n;
  logic quiet;
  int   mismatches;
  int   idle_cycles;

  timer_result_t pending_results[$];

  logic        live[NumSlots];
  logic [7:0]  live_owner[NumSlots];
  logic [15:0] live_timer[NumSlots];
  logic [30:0] live_period[NumSlots];
  logic        live_one_shot[NumSlots];
  logic [31:0] live_elapsed[NumSlots];

  kitt_req_if req_if ();
  kitt_rsp_if rsp_if ();

  keyed_interval_timer_table #(
    .SLOTS(NumSlots)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int find_timer_slot(logic [7:0] owner, logic [15:0] timer);
    for (int i = 0; i < NumSlots; i++) begin
      if (live[i] && live_owner[i] == owner && live_timer[i] == timer) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void push_result(kind_e kind, logic [7:0] owner, logic [15:0] timer,
                                      logic [31:0] elapsed, logic last);
    timer_result_t res;
    res.kind    = kind;
    res.owner   = owner;
    res.timer   = timer;
    res.elapsed = elapsed;
    res.last    = last;
    pending_results.push_back(res);
  endfunction

  function automatic void apply_timer_action(action_e act, logic [7:0] owner, logic [15:0] timer,
                                             logic [30:0] period, logic one_shot,
                                             logic [31:0] delta);
    int          hit;
    logic [32:0] sum;
    hit = find_timer_slot(owner, timer);
    case (act)
      ACT_ADD: begin
        if (hit < 0) begin
          for (int i = NumSlots - 1; i >= 0; i--) begin
            if (!live[i]) hit = i;
          end
        end
        if (hit < 0) begin
          push_result(KIND_FULL, '0, '0, '0, 1'b1);
        end else begin
          live[hit]          = 1'b1;
          live_owner[hit]    = owner;
          live_timer[hit]    = timer;
          live_period[hit]   = period;
          live_one_shot[hit] = one_shot;
          live_elapsed[hit]  = '0;
          push_result(KIND_DONE, '0, '0, '0, 1'b1);
        end
      end
      ACT_REMOVE: begin
        if (hit >= 0) live[hit] = 1'b0;
        push_result(KIND_DONE, '0, '0, '0, 1'b1);
      end
      ACT_REMOVE_OWNER: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (live[i] && live_owner[i] == owner) live[i] = 1'b0;
        end
        push_result(KIND_DONE, '0, '0, '0, 1'b1);
      end
      default: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (live[i]) begin
            sum = {1'b0, live_elapsed[i]} + {1'b0, delta};
            live_elapsed[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (live_elapsed[i] >= {1'b0, live_period[i]}) begin
              push_result(KIND_FIRED, live_owner[i], live_timer[i], live_elapsed[i], 1'b0);
              if (live_one_shot[i]) begin
                live[i] = 1'b0;
              end else begin
                live_elapsed[i] = '0;
              end
            end
          end
        end
        push_result(KIND_DONE, '0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic send_timer_cmd(action_e act, logic [7:0] owner, logic [15:0] timer,
                                logic [30:0] period, logic one_shot, logic [31:0] delta);
    int gap;
    gap = 0;
    while (!quiet && $urandom_range(0, 99) < 33) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.owner_key  <= owner;
    req_if.timer_key  <= timer;
    req_if.period     <= period;
    req_if.one_shot   <= one_shot;
    req_if.delta_time <= delta;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    apply_timer_action(act, owner, timer, period, one_shot, delta);
  endtask

  task automatic test_extremes();
    send_timer_cmd(ACT_TICK, 8'h00, 16'h0000, 31'h0, 1'b0, 32'hFFFF_FFFF);
    send_timer_cmd(ACT_ADD, 8'hFF, 16'hFFFF, 31'h7FFF_FFFF, 1'b0, 32'hFFFF_FFFF);
    send_timer_cmd(ACT_ADD, 8'h00, 16'h0000, 31'h0, 1'b1, 32'h0);
    send_timer_cmd(ACT_TICK, 8'hFF, 16'hFFFF, 31'h7FFF_FFFF, 1'b1, 32'h0);
    send_timer_cmd(ACT_TICK, 8'h00, 16'h0000, 31'h0, 1'b0, 32'd5);
    send_timer_cmd(ACT_TICK, 8'h00, 16'h0000, 31'h0, 1'b0, 32'hFFFF_FFFF);
    send_timer_cmd(ACT_ADD, 8'hFF, 16'hFFFF, 31'h0, 1'b0, 32'h0);
  endtask

  task automatic test_absent_keys();
    send_timer_cmd(ACT_REMOVE, 8'h01, 16'h0001, 31'h0, 1'b0, 32'h0);
    send_timer_cmd(ACT_REMOVE_OWNER, 8'h07, 16'h0000, 31'h0, 1'b0, 32'h0);
  endtask

  task automatic test_full_table();
    for (int i = 1; i < NumSlots; i++) begin
      send_timer_cmd(ACT_ADD, 8'h5A, 16'(i), 31'h0, 1'(i), 32'h0);
    end
    send_timer_cmd(ACT_ADD, 8'h33, 16'h0001, 31'h0, 1'b0, 32'h0);
    send_timer_cmd(ACT_ADD, 8'h5A, 16'h0002, 31'h0, 1'b1, 32'h0);
    send_timer_cmd(ACT_TICK, 8'h00, 16'h0000, 31'h0, 1'b0, 32'h8000_0000);
    send_timer_cmd(ACT_REMOVE, 8'hFF, 16'hFFFF, 31'h0, 1'b0, 32'h0);
    send_timer_cmd(ACT_REMOVE_OWNER, 8'h5A, 16'h0000, 31'h0, 1'b0, 32'h0);
  endtask

  task automatic test_random_traffic(int count);
    action_e     act;
    logic [7:0]  owner;
    logic [15:0] timer;
    logic [30:0] period;
    logic [31:0] delta;
    int          pick;
    int          live_slots[$];
    for (int n = 0; n < count; n++) begin
      pick  = $urandom_range(0, 99);
      act   = pick < 35 ? ACT_ADD : pick < 52 ? ACT_REMOVE :
              pick < 58 ? ACT_REMOVE_OWNER : ACT_TICK;
      owner = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      timer = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0:       period = 31'($urandom);
        1:       period = '0;
        2:       period = 31'($urandom_range(0, 500));
        default: period = 31'($urandom_range(1, 60));
      endcase
      case ($urandom_range(0, 9))
        0:       delta = $urandom;
        1:       delta = 32'hFFFF_FFFF;
        2, 3:    delta = $urandom_range(0, 1000);
        default: delta = $urandom_range(0, 40);
      endcase
      live_slots.delete();
      for (int i = 0; i < NumSlots; i++) begin
        if (live[i]) live_slots.push_back(i);
      end
      if (act != ACT_TICK && live_slots.size() != 0 && $urandom_range(0, 9) < 5) begin
        pick  = live_slots[$urandom_range(0, live_slots.size() - 1)];
        owner = live_owner[pick];
        timer = live_timer[pick];
      end
      send_timer_cmd(act, owner, timer, period, 1'($urandom), delta);
    end
  endtask

  always @(posedge clk) begin : check_results
    timer_result_t want;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      idle_cycles <= 0;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d", rsp_if.kind);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, rsp_if.kind);
          mismatches++;
        end
        if (rsp_if.fired_owner !== want.owner) begin
          $error("fired_owner: expected %0h, actual %0h", want.owner, rsp_if.fired_owner);
          mismatches++;
        end
        if (rsp_if.fired_timer !== want.timer) begin
          $error("fired_timer: expected %0h, actual %0h", want.timer, rsp_if.fired_timer);
          mismatches++;
        end
        if (rsp_if.fired_elapsed !== want.elapsed) begin
          $error("fired_elapsed: expected %0h, actual %0h", want.elapsed, rsp_if.fired_elapsed);
          mismatches++;
        end
        if (rsp_if.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, rsp_if.last);
          mismatches++;
        end
      end
    end else if (rst_n && req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
    end
    rsp_if.ready <= quiet || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    if (idle_cycles >= IdleLimit) begin
      $display("tb_keyed_interval_timer_table NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    quiet             = 1'b0;
    mismatches        = 0;
    idle_cycles       = 0;
    req_if.valid      = 1'b0;
    req_if.action     = ACT_ADD;
    req_if.owner_key  = '0;
    req_if.timer_key  = '0;
    req_if.period     = '0;
    req_if.one_shot   = 1'b0;
    req_if.delta_time = '0;
    rsp_if.ready      = 1'b0;
    for (int i = 0; i < NumSlots; i++) live[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_absent_keys();
    test_full_table();
    test_random_traffic(110);
    // A long stretch in which neither side holds back.
    quiet <= 1'b1;
    test_random_traffic(60);
    quiet <= 1'b0;
    test_random_traffic(50);
    req_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SweepCycles) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("results still expected at the end: %0d", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_keyed_interval_timer_table OK");
    end else begin
      $display("tb_keyed_interval_timer_table NOT OK");
    end
    $finish;
  end

endmodule
